@@ rtl/core/dwc_pkg.sv @@
`default_nettype none
package dwc_pkg;

    localparam int MAX_WIDTH  = 32;
    localparam int CHANNELS   = 8;
    localparam int NTAPS      = 9;
    localparam int SLOTS      = 3;
    localparam int LINE_DEPTH = SLOTS * MAX_WIDTH;
    localparam int LINE_AW    = $clog2(LINE_DEPTH);
    localparam int WT_AW      = $clog2(NTAPS);
    localparam int PIX_W      = 8 * CHANNELS;
    localparam int ROW_W      = 10;
    localparam int COL_W      = 5;
    localparam int CH_IW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_CW      = $clog2(CHANNELS + 1);

    typedef enum logic [1:0] {
        OP_PIXEL  = 2'd0,
        OP_WEIGHT = 2'd1,
        OP_BIAS   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_MULT   = 3'd0,
        REG_SHIFT  = 3'd1,
        REG_ZP     = 3'd2,
        REG_HEIGHT = 3'd3,
        REG_WIDTH  = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NEXT,
        ST_TAP,
        ST_REQ,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [31:0] mult;
        logic [5:0]  shift;
        logic [7:0]  zp;
    } rq_cfg_t;

    function automatic logic [1:0] mod3_small(input logic [2:0] v);
        logic [1:0] r;
        case (v) inside
            3'd0, 3'd3, 3'd6: r = 2'd0;
            3'd1, 3'd4:       r = 2'd1;
            3'd2, 3'd5:       r = 2'd2;
            default:          r = 2'd0;
        endcase
        return r;
    endfunction

    // 4 == 1 mod 3, so base-4 digit sums keep the residue
    function automatic logic [1:0] mod3_row(input logic [ROW_W-1:0] v);
        logic [3:0] s;
        logic [2:0] t;
        s = {2'b0, v[1:0]} + {2'b0, v[3:2]} + {2'b0, v[5:4]} + {2'b0, v[7:6]}
            + {2'b0, v[9:8]};
        t = {1'b0, s[1:0]} + {1'b0, s[3:2]};
        return mod3_small(t);
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/dwc_ram.sv @@
`default_nettype none
module dwc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 96
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ rtl/core/dwc_requant.sv @@
`default_nettype none
module dwc_requant import dwc_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              go,
    input  wire rq_cfg_t           cfg,
    input  wire logic [31:0]       acc [CHANNELS],
    output logic                   done,
    output logic signed [7:0]      res [8]
);

    logic             busy_reg, busy_next;
    logic [CH_CW-1:0] ch_reg, ch_next;
    logic             pv_reg, pv_next;
    logic [CH_IW-1:0] pch_reg;
    logic [62:0]      prod_reg;
    logic             done_reg, done_next;
    logic signed [7:0] res_reg [8];

    logic        neg;
    logic [31:0] absm;
    logic [31:0] cur;
    logic [30:0] relu;
    logic [63:0] half, rsum, q;
    logic signed [65:0] sq, rv;
    logic signed [7:0]  sat;

    always_comb begin
        neg  = cfg.mult[31];
        absm = neg ? (32'd0 - cfg.mult) : cfg.mult;
        cur  = acc[ch_reg[CH_IW-1:0]];
        relu = cur[31] ? 31'd0 : cur[30:0];
        half = (cfg.shift == 6'd0) ? 64'd0 : (64'd1 << (cfg.shift - 6'd1));
        rsum = {1'b0, prod_reg} + half;
        q    = rsum >> cfg.shift;
        sq   = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        rv   = sq + 66'($signed(cfg.zp));
        if (rv > 66'sd127) begin
            sat = 8'sd127;
        end else if (rv < -66'sd128) begin
            sat = -8'sd128;
        end else begin
            sat = rv[7:0];
        end
        busy_next = busy_reg;
        ch_next   = ch_reg;
        pv_next   = 1'b0;
        done_next = pv_reg && (pch_reg == CH_IW'(CHANNELS - 1));
        if (go) begin
            busy_next = 1'b1;
            ch_next   = '0;
        end else if (busy_reg) begin
            if (ch_reg < CH_CW'(CHANNELS)) begin
                pv_next = 1'b1;
                ch_next = ch_reg + 1'b1;
            end else begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ch_reg   <= '0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            ch_reg   <= ch_next;
            pv_reg   <= pv_next;
            done_reg <= done_next;
        end
        if (pv_next) begin
            prod_reg <= 63'(relu) * 63'(absm);
            pch_reg  <= ch_reg[CH_IW-1:0];
        end
        if (go) begin
            for (int i = 0; i < 8; i++) begin
                res_reg[i] <= '0;
            end
        end else if (pv_reg) begin
            res_reg[pch_reg] <= sat;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule
`default_nettype wire

@@ rtl/core/depthwise_conv3x3_bias_relu_requant_core.sv @@
// Each result passes a setup step, a tap loop that reads the nine taps from the line store
// and then drains the last product, requant (launch, channel-serial multiplies, rounding,
// done) and an output load. Weight and bias loads leave the core idle; a pixel word yields up
// to 34 results, each of which may also wait on m_tready. Reset (aresetn, synchronous, low)
// clears the row and column counters, control and config to defaults; line, weight and bias
// stores hold no reset value.
`default_nettype none
module depthwise_conv3x3_bias_relu_requant_core import dwc_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // opcode, data_ch0..7, load_index, bias_word; 2 pad bits
    input  wire logic [103:0] s_tdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // out_row, out_col, out_ch0..7; 1 pad bit
    output logic [79:0]       m_tdata,
    output logic              m_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [31:0]  cfg_wdata
);

    logic [1:0]       in_op;
    logic [PIX_W-1:0] in_pix;
    logic [3:0]       in_idx;
    logic [31:0]      in_bias;

    assign in_op   = s_tdata[1:0];
    assign in_pix  = s_tdata[2 +: PIX_W];
    assign in_idx  = s_tdata[69:66];
    assign in_bias = s_tdata[101:70];

    logic [31:0] mult_reg;
    logic [5:0]  shift_reg;
    logic [7:0]  zp_reg;
    logic [9:0]  height_reg;
    logic [5:0]  width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mult_reg   <= 32'd1;
            shift_reg  <= 6'd0;
            zp_reg     <= 8'd0;
            height_reg <= 10'd14;
            width_reg  <= 6'd14;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_MULT:   mult_reg   <= cfg_wdata;
                REG_SHIFT:  shift_reg  <= cfg_wdata[5:0];
                REG_ZP:     zp_reg     <= cfg_wdata[7:0];
                REG_HEIGHT: height_reg <= cfg_wdata[9:0];
                REG_WIDTH:  width_reg  <= cfg_wdata[5:0];
                default: ;
            endcase
        end
    end

    state_t            state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  rm1_reg, rm1_next;
    logic [COL_W-1:0]  cm1_reg, cm1_next;
    logic [COL_W-1:0]  wlast_reg, wlast_next;
    logic [ROW_W-1:0]  hlast_reg, hlast_next;
    logic [COL_W-1:0]  fk_reg, fk_next;
    logic              job_a_reg, job_a_next;
    logic              job_b_reg, job_b_next;
    logic              flush_reg, flush_next;
    logic [ROW_W-1:0]  orow_reg, orow_next;
    logic [COL_W-1:0]  ocol_reg, ocol_next;
    logic              last_reg, last_next;
    logic [1:0]        dy_reg, dy_next;
    logic [1:0]        dx_reg, dx_next;
    logic [3:0]        tap_reg, tap_next;
    logic              pend_reg, pend_next;
    logic              pend_ok_reg, pend_ok_next;
    logic              rq_go_reg, rq_go_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [79:0]       m_tdata_reg;
    logic              m_tlast_reg;
    logic [31:0]       acc_reg [CHANNELS];
    logic [31:0]       acc_next [CHANNELS];
    logic [31:0]       bias_reg [CHANNELS];

    logic [5:0]        w_eff;
    logic [ROW_W-1:0]  h_eff;
    logic [COL_W-1:0]  w_last;
    logic [ROW_W-1:0]  h_last;
    logic [COL_W-1:0]  c_cur;
    logic [ROW_W-1:0]  r_cur;
    logic              accept;
    logic              out_free;
    logic              out_load;

    logic                line_we, wt_we;
    logic [LINE_AW-1:0]  line_waddr, line_raddr;
    logic [WT_AW-1:0]    wt_raddr;
    logic [PIX_W-1:0]    line_rdata, wt_rdata;

    logic signed [6:0]   ix;
    logic signed [11:0]  iy;
    logic                ok_x, ok_y;
    logic [1:0]          oslot, rslot;
    logic signed [15:0]  prod [CHANNELS];

    logic               rq_done;
    logic signed [7:0]  rq_res [8];
    rq_cfg_t            rq_cfg;

    assign rq_cfg = '{mult: mult_reg, shift: shift_reg, zp: zp_reg};

    always_comb begin
        if (width_reg == 6'd0) begin
            w_eff = 6'd1;
        end else if (width_reg > 6'(MAX_WIDTH)) begin
            w_eff = 6'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        h_eff  = (height_reg == '0) ? ROW_W'(1) : height_reg;
        w_last = COL_W'(w_eff - 6'd1);
        h_last = h_eff - 1'b1;
        c_cur  = (col_reg > w_last) ? w_last : col_reg;
        r_cur  = (row_reg > h_last) ? h_last : row_reg;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_OUT) && out_free;

    assign line_we    = accept && (in_op == OP_PIXEL);
    assign line_waddr = LINE_AW'(mod3_row(r_cur) * MAX_WIDTH) + LINE_AW'(c_cur);
    assign wt_we      = accept && (in_op == OP_WEIGHT) && (in_idx < 4'(NTAPS));

    always_comb begin
        ix    = $signed({2'b00, ocol_reg}) + $signed({5'b0, dx_reg}) - 7'sd1;
        iy    = $signed({2'b00, orow_reg}) + $signed({10'b0, dy_reg}) - 12'sd1;
        ok_x  = !ix[6] && (ix[5:0] <= {1'b0, wlast_reg});
        ok_y  = !iy[11] && (iy[10:0] <= {1'b0, hlast_reg});
        oslot = mod3_row(orow_reg);
        rslot = mod3_small({1'b0, oslot} + {1'b0, dy_reg} + 3'd2);
        line_raddr = LINE_AW'(rslot * MAX_WIDTH) + LINE_AW'(ix[COL_W-1:0]);
        wt_raddr   = WT_AW'(tap_reg);
        for (int c = 0; c < CHANNELS; c++) begin
            prod[c] = $signed(line_rdata[8*c +: 8]) * $signed(wt_rdata[8*c +: 8]);
        end
    end

    always_comb begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        rm1_next      = rm1_reg;
        cm1_next      = cm1_reg;
        wlast_next    = wlast_reg;
        hlast_next    = hlast_reg;
        fk_next       = fk_reg;
        job_a_next    = job_a_reg;
        job_b_next    = job_b_reg;
        flush_next    = flush_reg;
        orow_next     = orow_reg;
        ocol_next     = ocol_reg;
        last_next     = last_reg;
        dy_next       = dy_reg;
        dx_next       = dx_reg;
        tap_next      = tap_reg;
        pend_next     = 1'b0;
        pend_ok_next  = 1'b0;
        rq_go_next    = 1'b0;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        acc_next      = acc_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (in_op == OP_PIXEL)) begin
                    rm1_next   = r_cur - 1'b1;
                    cm1_next   = c_cur - 1'b1;
                    wlast_next = w_last;
                    hlast_next = h_last;
                    fk_next    = '0;
                    job_a_next = (r_cur != '0) && (c_cur != '0);
                    job_b_next = (r_cur != '0) && (c_cur == w_last);
                    flush_next = (r_cur == h_last) && (c_cur == w_last);
                    if (c_cur == w_last) begin
                        col_next = '0;
                        row_next = (r_cur == h_last) ? '0 : r_cur + 1'b1;
                    end else begin
                        col_next = c_cur + 1'b1;
                        row_next = r_cur;
                    end
                    if (r_cur != '0 || (r_cur == h_last && c_cur == w_last)) begin
                        state_next = (r_cur != '0 && c_cur != '0) || (c_cur == w_last)
                                   ? ST_NEXT : ST_IDLE;
                    end
                end
            end
            ST_NEXT: begin
                if (job_a_reg) begin
                    orow_next  = rm1_reg;
                    ocol_next  = cm1_reg;
                    job_a_next = 1'b0;
                    last_next  = !job_b_reg && !flush_reg;
                end else if (job_b_reg) begin
                    orow_next  = rm1_reg;
                    ocol_next  = wlast_reg;
                    job_b_next = 1'b0;
                    last_next  = !flush_reg;
                end else begin
                    orow_next = hlast_reg;
                    ocol_next = fk_reg;
                    fk_next   = fk_reg + 1'b1;
                    last_next = (fk_reg == wlast_reg);
                    if (fk_reg == wlast_reg) begin
                        flush_next = 1'b0;
                    end
                end
                for (int c = 0; c < CHANNELS; c++) begin
                    acc_next[c] = bias_reg[c];
                end
                dy_next    = '0;
                dx_next    = '0;
                tap_next   = '0;
                state_next = ST_TAP;
            end
            ST_TAP: begin
                if (pend_reg && pend_ok_reg) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        acc_next[c] = acc_reg[c] + 32'(prod[c]);
                    end
                end
                if (tap_reg == 4'(NTAPS)) begin
                    rq_go_next = 1'b1;
                    state_next = ST_REQ;
                end else begin
                    pend_next    = 1'b1;
                    pend_ok_next = ok_x && ok_y;
                    tap_next     = tap_reg + 1'b1;
                    if (dx_reg == 2'd2) begin
                        dx_next = '0;
                        dy_next = dy_reg + 1'b1;
                    end else begin
                        dx_next = dx_reg + 1'b1;
                    end
                end
            end
            ST_REQ: begin
                if (rq_done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    state_next = (job_a_reg || job_b_reg || flush_reg) ? ST_NEXT : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            row_reg      <= '0;
            col_reg      <= '0;
            job_a_reg    <= 1'b0;
            job_b_reg    <= 1'b0;
            flush_reg    <= 1'b0;
            pend_reg     <= 1'b0;
            pend_ok_reg  <= 1'b0;
            rq_go_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            job_a_reg    <= job_a_next;
            job_b_reg    <= job_b_next;
            flush_reg    <= flush_next;
            pend_reg     <= pend_next;
            pend_ok_reg  <= pend_ok_next;
            rq_go_reg    <= rq_go_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        rm1_reg   <= rm1_next;
        cm1_reg   <= cm1_next;
        wlast_reg <= wlast_next;
        hlast_reg <= hlast_next;
        fk_reg    <= fk_next;
        orow_reg  <= orow_next;
        ocol_reg  <= ocol_next;
        last_reg  <= last_next;
        dy_reg    <= dy_next;
        dx_reg    <= dx_next;
        tap_reg   <= tap_next;
        acc_reg   <= acc_next;
        if (accept && (in_op == OP_BIAS) && (in_idx < 4'(CHANNELS))) begin
            bias_reg[in_idx[CH_IW-1:0]] <= in_bias;
        end
        if (out_load) begin
            m_tdata_reg <= {1'b0, rq_res[7], rq_res[6], rq_res[5], rq_res[4],
                            rq_res[3], rq_res[2], rq_res[1], rq_res[0],
                            ocol_reg, orow_reg};
            m_tlast_reg <= last_reg;
        end
    end

    dwc_ram #(.WIDTH(PIX_W), .DEPTH(LINE_DEPTH)) u_line_ram (
        .aclk  (aclk),
        .we    (line_we),
        .waddr (line_waddr),
        .wdata (in_pix),
        .raddr (line_raddr),
        .rdata (line_rdata)
    );

    dwc_ram #(.WIDTH(PIX_W), .DEPTH(NTAPS)) u_weight_ram (
        .aclk  (aclk),
        .we    (wt_we),
        .waddr (WT_AW'(in_idx)),
        .wdata (in_pix),
        .raddr (wt_raddr),
        .rdata (wt_rdata)
    );

    dwc_requant u_requant (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (rq_go_reg),
        .cfg     (rq_cfg),
        .acc     (acc_reg),
        .done    (rq_done),
        .res     (rq_res)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_req_done_in_req: assert property (@(posedge aclk) disable iff (!aresetn)
        rq_done |-> (state_reg == ST_REQ))
        else $error("requant finished outside requant phase");

    a_tap_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAP) |-> (tap_reg <= 4'(NTAPS)))
        else $error("tap counter overran");

    a_out_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_tvalid_reg)
        else $error("result not presented after load");

    a_idle_no_jobs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !(job_a_reg || job_b_reg || flush_reg))
        else $error("pending output while idle");

endmodule
`default_nettype wire

@@ test/depthwise_conv3x3_bias_relu_requant_core_test.sv @@
`default_nettype none
module depthwise_conv3x3_bias_relu_requant_core_test import dwc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        op_t         op;
        logic [63:0] pix;     // ch0 in the low byte
        logic [3:0]  idx;
        logic [31:0] bias;
    } word_t;

    typedef struct packed {
        logic [9:0]  row;
        logic [4:0]  col;
        logic [63:0] pix;
        logic        last;
    } opix_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic [103:0] s_tdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [79:0]  m_tdata;
    logic         m_tlast;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_addr = '0;
    logic [31:0]  cfg_wdata = '0;

    depthwise_conv3x3_bias_relu_requant_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state
    logic signed [7:0]  line_px [LINE_DEPTH][8];
    logic signed [7:0]  tap_wt [NTAPS][8];
    logic signed [31:0] ch_bias [8];
    int                 row_cnt, col_cnt;
    logic signed [31:0] q_mult;
    int                 q_shift;
    logic signed [7:0]  q_zp;
    int                 fr_h, fr_w;

    opix_t expected_pix[$];
    int    errors = 0;
    int    cycles = 0;
    int    stall_pct = 0;
    int    burst_left = 0;
    int    items = 0;

    function automatic int eff_w();
        return (fr_w < 1) ? 1 : (fr_w > MAX_WIDTH) ? MAX_WIDTH : fr_w;
    endfunction
    function automatic int eff_h();
        return (fr_h < 1) ? 1 : fr_h;
    endfunction

    function automatic logic [7:0] requant(logic [31:0] acc);
        logic [63:0] relu, absm, mag, half;
        longint r;
        relu = acc[31] ? 64'd0 : {32'd0, acc};
        absm = q_mult[31] ? (64'd0 - {{32{q_mult[31]}}, q_mult}) : {32'd0, q_mult};
        mag = relu * absm;
        half = (q_shift != 0) ? (64'd1 << (q_shift - 1)) : 64'd0;
        r = longint'((mag + half) >> q_shift);
        if (q_mult[31]) r = -r;
        r += q_zp;
        if (r > 127) r = 127;
        if (r < -128) r = -128;
        return r[7:0];
    endfunction

    function automatic void push_pixel(int orow, int ocol, int h, int w, logic last);
        opix_t o;
        logic [31:0] acc;
        int iy, ix;
        o.row = orow[9:0];
        o.col = ocol[4:0];
        o.last = last;
        for (int c = 0; c < 8; c++) begin
            acc = ch_bias[c];
            for (int dy = 0; dy < 3; dy++)
                for (int dx = 0; dx < 3; dx++) begin
                    iy = orow + dy - 1;
                    ix = ocol + dx - 1;
                    if (iy >= 0 && iy < h && ix >= 0 && ix < w)
                        acc += 32'(int'(line_px[(iy % 3) * MAX_WIDTH + ix][c]) *
                                   int'(tap_wt[dy * 3 + dx][c]));
                end
            o.pix[c*8 +: 8] = requant(acc);
        end
        expected_pix.push_back(o);
    endfunction

    function automatic void conv_predict(word_t wd);
        int h, w, r, c, total, n;
        case (wd.op)
            OP_WEIGHT: if (wd.idx < NTAPS)
                for (int k = 0; k < 8; k++) tap_wt[wd.idx][k] = wd.pix[k*8 +: 8];
            OP_BIAS: if (wd.idx < CHANNELS) ch_bias[wd.idx] = wd.bias;
            OP_PIXEL: begin
                w = eff_w();
                h = eff_h();
                c = (col_cnt > w - 1) ? w - 1 : col_cnt;
                r = (row_cnt > h - 1) ? h - 1 : row_cnt;
                for (int k = 0; k < 8; k++) line_px[(r % 3) * MAX_WIDTH + c][k] = wd.pix[k*8 +: 8];
                total = 0;
                if (r >= 1) total += (c >= 1) + (c == w - 1);
                if (r == h - 1 && c == w - 1) total += w;
                n = 0;
                if (r >= 1) begin
                    if (c >= 1) begin
                        n++;
                        push_pixel(r - 1, c - 1, h, w, n == total);
                    end
                    if (c == w - 1) begin
                        n++;
                        push_pixel(r - 1, w - 1, h, w, n == total);
                    end
                end
                if (r == h - 1 && c == w - 1)
                    for (int k = 0; k < w; k++) begin
                        n++;
                        push_pixel(h - 1, k, h, w, n == total);
                    end
                if (c == w - 1) begin
                    col_cnt = 0;
                    row_cnt = (r == h - 1) ? 0 : r + 1;
                end else begin
                    col_cnt = c + 1;
                    row_cnt = r;
                end
            end
            default: ;
        endcase
    endfunction

    // output checker and receiver stalls
    always @(posedge aclk) begin
        opix_t e;
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pix.size() == 0) begin
                $display("%t unexpected word: actual %h last %b", $realtime, m_tdata, m_tlast);
                errors++;
            end else begin
                e = expected_pix.pop_front();
                if (m_tdata[9:0] != e.row || m_tdata[14:10] != e.col ||
                    m_tdata[78:15] != e.pix || m_tlast != e.last) begin
                    $display("%t mismatch: expected row %0d col %0d ch %h last %b",
                             $realtime, e.row, e.col, e.pix, e.last);
                    $display("%t           actual   row %0d col %0d ch %h last %b",
                             $realtime, m_tdata[9:0], m_tdata[14:10], m_tdata[78:15], m_tlast);
                    errors++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= stall_pct);
        if (cycles > 5000000) begin
            $display("depthwise_conv3x3_bias_relu_requant_core test failed");
            $finish;
        end
    end

    task automatic send_word(word_t wd);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(1, 20);
        end
        s_tdata <= {2'b00, wd.bias, wd.idx, wd.pix, wd.op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        conv_predict(wd);
        burst_left--;
        items++;
    endtask

    task automatic write_cfg(logic [31:0] mult, int shift, logic [7:0] zp, int h, int w);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_pix.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        for (int i = 0; i < 5; i++) begin
            cfg_we <= 1'b1;
            cfg_addr <= i[2:0];
            case (cfg_idx_t'(i))
                REG_MULT:   cfg_wdata <= mult;
                REG_SHIFT:  cfg_wdata <= 32'(shift);
                REG_ZP:     cfg_wdata <= {24'd0, zp};
                REG_HEIGHT: cfg_wdata <= 32'(h);
                default:    cfg_wdata <= 32'(w);
            endcase
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        q_mult = mult;
        q_shift = shift & 63;
        q_zp = zp;
        fr_h = h & 1023;
        fr_w = w & 63;
    endtask

    function automatic word_t mk(op_t op, logic [63:0] pix, logic [3:0] idx, logic [31:0] bias);
        word_t wd;
        wd.op = op;
        wd.pix = pix;
        wd.idx = idx;
        wd.bias = bias;
        return wd;
    endfunction

    function automatic word_t rnd_word(bit noise);
        word_t wd;
        wd = mk(OP_PIXEL, {$urandom, $urandom}, 4'($urandom), $urandom);
        if ($urandom_range(3) == 0) wd.pix = {8{8'($urandom_range(1) ? 8'h7f : 8'h80)}};
        if (noise) wd.op = op_t'($urandom_range(1, 3));
        return wd;
    endfunction

    word_t dir_tab[$];

    initial begin
        int h, w, npix, sel;
        logic [31:0] mult;
        q_mult = 1; q_shift = 0; q_zp = 0; fr_h = 14; fr_w = 14;
        row_cnt = 0; col_cnt = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_cfg(32'd1, 0, 8'd0, 2, 3);

        for (int t = 0; t < NTAPS; t++)
            dir_tab.push_back(mk(OP_WEIGHT, (t % 2) ? {8{8'h7f}} : {8{8'h80}}, 4'(t), '0));
        for (int c = 0; c < CHANNELS; c++)
            dir_tab.push_back(mk(OP_BIAS, '0, 4'(c),
                (c == 0) ? 32'h7fffffff : (c == 1) ? 32'h80000000 : 32'(c * 1000)));
        dir_tab.push_back(mk(OP_NONE, '1, 4'd0, '1));       // unused opcode
        dir_tab.push_back(mk(OP_WEIGHT, '1, 4'd9, '0));     // tap out of range
        dir_tab.push_back(mk(OP_WEIGHT, '0, 4'd15, '0));
        dir_tab.push_back(mk(OP_BIAS, '0, 4'd8, '1));       // channel out of range
        dir_tab.push_back(mk(OP_PIXEL, {8{8'h7f}}, '0, '0));
        dir_tab.push_back(mk(OP_PIXEL, {8{8'h80}}, '0, '0));
        dir_tab.push_back(mk(OP_PIXEL, 64'h0, '0, '0));
        dir_tab.push_back(mk(OP_PIXEL, 64'h807f807f807f807f, '0, '0));
        dir_tab.push_back(mk(OP_PIXEL, 64'h01ff01ff01ff01ff, '0, '0));
        dir_tab.push_back(mk(OP_PIXEL, {8{8'h7f}}, '0, '0));
        foreach (dir_tab[i]) send_word(dir_tab[i]);

        while (items < 400) begin
            sel = $urandom_range(9);
            mult = (sel == 0) ? 32'h80000000 : (sel == 1) ? 32'h7fffffff :
                   (sel < 5) ? 32'($urandom_range(1, 4000)) : $urandom;
            sel = $urandom_range(9);
            h = (sel == 0) ? 0 : (sel == 1) ? 1 : $urandom_range(2, 4);
            sel = $urandom_range(11);
            w = (sel == 0) ? 0 : (sel == 1) ? 32 : (sel == 2) ? 40 : (sel == 3) ? 63 :
                $urandom_range(1, 8);
            stall_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 80);
            write_cfg(mult, ($urandom_range(3) == 0) ? 62 : $urandom_range(0, 24),
                      8'($urandom_range(3) == 0 ? ($urandom_range(1) ? 127 : -128) :
                         $urandom_range(0, 255)), h, w);
            for (int f = 0; f < (h < 1 ? 3 : 2); f++) begin
                npix = eff_h() * eff_w();
                while (npix > 0) begin
                    if ($urandom_range(9) == 0) send_word(rnd_word(1'b1));
                    else begin
                        send_word(rnd_word(1'b0));
                        npix--;
                    end
                end
            end
        end
        s_tvalid <= 1'b0;
        while (expected_pix.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0 && expected_pix.size() == 0) begin
            $display("depthwise_conv3x3_bias_relu_requant_core test passed");
        end else begin
            $display("depthwise_conv3x3_bias_relu_requant_core test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
